// ----- rtl/core/b64c_pkg.sv -----
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, constants and character functions of the base64 stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam int unsigned JOB_Q_DEPTH = 2;
  localparam int unsigned JOB_RES_MAX = 4;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } b64c_mode_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_in;
    logic       message_last;
  } b64c_in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       has_data;
    logic       status;
    logic       run_last;
    logic       message_end;
  } b64c_out_t;

  // One accepted item's results; res[0] goes out first.
  typedef struct packed {
    logic [1:0]                        last_idx;
    b64c_out_t [JOB_RES_MAX-1:0]       res;
  } b64c_job_t;

  // Six-bit digit to alphabet character.
  function automatic logic [7:0] b64c_enc_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd26) begin
      c = 8'h41 + {2'b00, d};
    end else if (d < 6'd52) begin
      c = 8'h61 + {2'b00, d} - 8'd26;
    end else if (d < 6'd62) begin
      c = 8'h30 + {2'b00, d} - 8'd52;
    end else if (d == 6'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

  // Character to {ok, digit}; ok low for characters outside the alphabet.
  function automatic logic [6:0] b64c_dec_char(input logic [7:0] c);
    logic [6:0] r;
    logic [7:0] t;
    r = 7'd0;
    t = 8'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      r = {1'b1, t[5:0]};
    end else if (c == CHAR_PLUS) begin
      r = {1'b1, 6'd62};
    end else if (c == CHAR_SLASH) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/base64_stream_codec_core.sv -----
// ----------------------------------------------------------------------------
// base64_stream_codec_core
// Streaming base64 codec, standard alphabet: bytes to characters in encode
// mode, characters to bytes in decode mode.
// ----------------------------------------------------------------------------
// Channel  Handshake              Payload
// req      req_valid / req_stall  req  (mode, data_in, message_last)
// rsp      rsp_valid / rsp_stall  rsp  (data_out, has_data, status, run_last,
//                                       message_end)
//
// One item is taken per cycle while the job queue has room; the front updates
// the codec state in that same cycle. Results leave one per cycle, unless rsp
// stalls, from the output register, so an encode item's four characters hold
// the back part until all have left; a decode item has at most one result.
// The first result passes a queue slot, the current-job register and the
// output register. Reset is synchronous and clears codec state, queue and
// output valid. A stall on rsp backs up through the queue to req_stall.
// ----------------------------------------------------------------------------
module base64_stream_codec_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  b64c_pkg::b64c_in_t   req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output b64c_pkg::b64c_out_t  rsp
);
  import b64c_pkg::*;

  b64c_job_t  push_job;
  b64c_job_t  head_job;
  logic       push;
  logic       pop;
  logic       q_full;
  logic       q_not_empty;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  b64c_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (head_job)
  );

  b64c_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .pop         (pop),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp)
  );

endmodule

// ----- rtl/core/b64c_front.sv -----
// ----------------------------------------------------------------------------
// b64c_front
// Accepts items, keeps the encode and decode state and builds one result job
// per item that produces output.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  b64c_pkg::b64c_in_t  req,
  input  logic              q_full,
  output logic              push,
  output b64c_pkg::b64c_job_t job
);
  import b64c_pkg::*;

  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  held_count, held_count_next;
  logic [11:0] digit_acc, digit_acc_next;
  logic [2:0]  pending_bits, pending_bits_next;
  logic        error_seen, error_seen_next;

  logic        accept;
  logic        last;
  logic [1:0]  cnt;
  logic [23:0] v;
  logic [7:0]  c2, c3;
  logic [6:0]  dig;
  logic [3:0]  bits;
  logic [3:0]  bits_rem;
  logic        skip_char;

  assign req_stall = q_full;
  assign accept    = req_valid && !q_full;
  assign last      = req.message_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes   <= '0;
      held_count   <= '0;
      digit_acc    <= '0;
      pending_bits <= '0;
      error_seen   <= 1'b0;
    end else begin
      held_bytes   <= held_bytes_next;
      held_count   <= held_count_next;
      digit_acc    <= digit_acc_next;
      pending_bits <= pending_bits_next;
      error_seen   <= error_seen_next;
    end
  end

  always_comb begin
    held_bytes_next   = held_bytes;
    held_count_next   = held_count;
    digit_acc_next    = digit_acc;
    pending_bits_next = pending_bits;
    error_seen_next   = error_seen;
    push      = 1'b0;
    job       = '0;
    cnt       = (held_count == 2'd3) ? 2'd2 : held_count;
    v         = '0;
    c2        = CHAR_PAD;
    c3        = CHAR_PAD;
    dig       = b64c_dec_char(req.data_in);
    bits      = {1'b0, pending_bits} + 4'd6;
    if (bits > 4'd12) begin
      bits = 4'd12;
    end
    bits_rem  = bits - 4'd8;
    skip_char = (req.data_in == CHAR_PAD) || (req.data_in == CHAR_CR) ||
                (req.data_in == CHAR_LF) || (req.data_in == CHAR_SPACE);

    if (accept) begin
      if (req.mode == MODE_ENCODE) begin
        if (!last && cnt != 2'd2) begin
          if (cnt == 2'd0) begin
            held_bytes_next = {req.data_in, 8'h00};
          end else begin
            held_bytes_next = {held_bytes[15:8], req.data_in};
          end
          held_count_next = cnt + 2'd1;
        end else begin
          case (cnt)
            2'd0:    v = {req.data_in, 16'h0000};
            2'd1:    v = {held_bytes[15:8], req.data_in, 8'h00};
            default: v = {held_bytes, req.data_in};
          endcase
          if (cnt != 2'd0) begin
            c2 = b64c_enc_char(v[11:6]);
          end
          if (cnt == 2'd2) begin
            c3 = b64c_enc_char(v[5:0]);
          end
          job.last_idx = 2'd3;
          job.res[0]   = '{b64c_enc_char(v[23:18]), 1'b1, 1'b0, 1'b0, 1'b0};
          job.res[1]   = '{b64c_enc_char(v[17:12]), 1'b1, 1'b0, 1'b0, 1'b0};
          job.res[2]   = '{c2, 1'b1, 1'b0, 1'b0, 1'b0};
          job.res[3]   = '{c3, 1'b1, 1'b0, 1'b1, last};
          push            = 1'b1;
          held_bytes_next = '0;
          held_count_next = '0;
        end
      end else begin
        job.last_idx = 2'd0;
        if (error_seen) begin
          if (last) begin
            job.res[0] = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
            push       = 1'b1;
          end
        end else if (skip_char) begin
          if (last) begin
            job.res[0] = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
            push       = 1'b1;
          end
        end else if (!dig[6]) begin
          job.res[0]      = '{8'h00, 1'b0, 1'b1, 1'b1, last};
          push            = 1'b1;
          error_seen_next = 1'b1;
        end else begin
          digit_acc_next = {digit_acc[5:0], dig[5:0]};
          if (bits >= 4'd8) begin
            job.res[0]        = '{digit_acc_next[bits_rem +: 8], 1'b1, 1'b0,
                                  1'b1, last};
            push              = 1'b1;
            pending_bits_next = bits_rem[2:0];
          end else begin
            pending_bits_next = bits[2:0];
            if (last) begin
              job.res[0] = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b1};
              push       = 1'b1;
            end
          end
        end
      end
      // The last item of either mode clears everything.
      if (last) begin
        held_bytes_next   = '0;
        held_count_next   = '0;
        digit_acc_next    = '0;
        pending_bits_next = '0;
        error_seen_next   = 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/b64c_queue.sv -----
// ----------------------------------------------------------------------------
// b64c_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64c_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64c_pkg::b64c_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output b64c_pkg::b64c_job_t head
);
  import b64c_pkg::*;

  localparam int unsigned PtrW = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(JOB_Q_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(JOB_Q_DEPTH - 1);

  b64c_job_t          slots [JOB_Q_DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;
  logic               do_pop;

  assign full      = (count == CntW'(JOB_Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_pop    = pop && not_empty;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/b64c_back.sv -----
// ----------------------------------------------------------------------------
// b64c_back
// Takes jobs from the queue and sends their results one per cycle, while rsp
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  b64c_pkg::b64c_job_t q_head,
  output logic              pop,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output b64c_pkg::b64c_out_t rsp
);
  import b64c_pkg::*;

  b64c_job_t  cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       advance;
  logic       cur_done;
  logic       load;

  assign advance  = !rsp_valid || !rsp_stall;
  assign cur_done = cur_valid && advance && (idx == cur.last_idx);
  assign load     = !cur_valid || cur_done;
  assign pop      = load && q_not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (advance) begin
        rsp_valid <= cur_valid;
      end
      if (load) begin
        cur_valid <= q_not_empty;
        idx       <= '0;
      end else if (advance) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (advance && cur_valid) begin
      rsp <= cur.res[idx];
    end
  end

endmodule
